### sv/lzw_pkg.sv
package lzw_pkg;

  localparam int unsigned WIDEST_CODE_DEF = 12;
  localparam int unsigned START_WIDTH     = 9;
  localparam int unsigned DEF_MAX_BITS    = 12;
  localparam int unsigned CLEAR_CODE      = 256;
  localparam int unsigned END_CODE        = 257;
  localparam int unsigned FIRST_FREE      = 258;
  localparam int unsigned BUF_BITS        = 24;

  // Configuration register indexes.
  localparam logic REG_MAX_CODE_BITS = 1'b0;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_PUT,
    ST_DRAIN,
    ST_LASTCHK,
    ST_PAD
  } state_e;

  typedef enum logic [1:0] {
    PH_MISS,
    PH_CLEAR,
    PH_FINAL,
    PH_ENDC
  } phase_e;

endpackage

### sv/lzw_ram.sv
module lzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/lzw_front.sv
module lzw_front
  import lzw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);

  // Two-entry queue between the input port and the dictionary engine.
  item_t      slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_item_i;
    end
  end

endmodule

### sv/lzw_back.sv
module lzw_back
  import lzw_pkg::*;
#(
  parameter int unsigned WIDEST_CODE = WIDEST_CODE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] max_bits_i,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  item_t      q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_end_o
);

  localparam int unsigned W  = WIDEST_CODE;
  localparam int unsigned IW = W + 8;
  localparam int unsigned FW = W + 1;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [W-1:0]        prefix_q, prefix_d;
  logic                have_q, have_d;
  logic [FW-1:0]       free_q, free_d;
  logic [4:0]          width_q, width_d;
  logic [BUF_BITS-1:0] buf_q, buf_d;
  logic [4:0]          bits_q, bits_d;
  logic [W-1:0]        code_q, code_d;
  logic [4:0]          w_q, w_d;
  logic                clr_q, clr_d;
  logic                last_q, last_d;
  logic [7:0]          byte_q, byte_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [W-1:0]        cand_q, cand_d;
  logic                inr_q, inr_d;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_end_q, out_end_d;

  logic          child_we, key_we;
  logic [IW-1:0] child_raddr;
  logic [W-1:0]  child_rdata;
  logic [IW-1:0] key_rdata;

  logic [4:0]          lim;
  logic                out_free;
  logic [FW-1:0]       free_plus;
  logic                grow;
  logic                hit;
  logic [BUF_BITS-1:0] buf_put;
  logic [4:0]          bits_m8;

  always_comb begin
    if (max_bits_i > 5'(W)) begin
      lim = 5'(W);
    end else if (max_bits_i < 5'(START_WIDTH)) begin
      lim = (DEF_MAX_BITS < W) ? 5'(DEF_MAX_BITS) : 5'(W);
    end else begin
      lim = max_bits_i;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign free_plus   = free_q + FW'(1);
  assign grow        = (free_plus == (FW'(1) << width_q));
  assign hit         = inr_q && (key_rdata == idx_q);
  assign buf_put     = (buf_q << w_q)
                     | (BUF_BITS'(code_q) & ((BUF_BITS'(1) << w_q) - BUF_BITS'(1)));
  assign bits_m8     = bits_q - 5'd8;
  assign child_raddr = {prefix_q, q_item_i.data};

  lzw_ram #(.WIDTH(W), .DEPTH(1 << IW)) u_child (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (idx_q),
    .wdata_i (free_q[W-1:0]),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  // The key store maps each live code back to its (prefix, byte) pair, so a stale
  // child entry from an earlier dictionary is recognised and ignored.
  lzw_ram #(.WIDTH(IW), .DEPTH(1 << W)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_q[W-1:0]),
    .wdata_i (idx_q),
    .raddr_i (child_rdata),
    .rdata_o (key_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = have_q ? ST_RD1 : ST_LASTCHK;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      // An entry that was never written gives no confirmed hit and is taken as a miss.
      ST_RD2: begin
        if (hit) begin
          state_d = ST_LASTCHK;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT:  state_d = ST_DRAIN;
      ST_DRAIN: begin
        if (bits_q < 5'd8) begin
          case (phase_q)
            PH_MISS:  state_d = clr_q ? ST_PUT : ST_LASTCHK;
            PH_CLEAR: state_d = ST_LASTCHK;
            PH_FINAL: state_d = ST_PUT;
            PH_ENDC:  state_d = (bits_q != 5'd0) ? ST_PAD : ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LASTCHK: state_d = last_q ? ST_PUT : ST_IDLE;
      ST_PAD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    prefix_d    = prefix_q;
    have_d      = have_q;
    free_d      = free_q;
    width_d     = width_q;
    buf_d       = buf_q;
    bits_d      = bits_q;
    code_d      = code_q;
    w_d         = w_q;
    clr_d       = clr_q;
    last_d      = last_q;
    byte_d      = byte_q;
    idx_d       = idx_q;
    cand_d      = cand_q;
    inr_d       = inr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    q_pop_o     = 1'b0;
    child_we    = 1'b0;
    key_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          last_d  = q_item_i.last;
          byte_d  = q_item_i.data;
          idx_d   = child_raddr;
          if (!have_q) begin
            prefix_d = W'(q_item_i.data);
            have_d   = 1'b1;
          end
        end
      end
      ST_RD1: begin
        cand_d = child_rdata;
        inr_d  = (child_rdata >= W'(FIRST_FREE)) && ({1'b0, child_rdata} < free_q);
      end
      ST_RD2: begin
        if (hit) begin
          prefix_d = cand_q;
        end else begin
          child_we = 1'b1;
          key_we   = 1'b1;
          code_d   = prefix_q;
          w_d      = width_q;
          phase_d  = PH_MISS;
          prefix_d = W'(byte_q);
          free_d   = free_plus;
          clr_d    = 1'b0;
          if (grow) begin
            width_d = width_q + 5'd1;
            clr_d   = (width_q + 5'd1) > lim;
          end
        end
      end
      ST_PUT: begin
        buf_d  = buf_put;
        bits_d = bits_q + w_q;
      end
      ST_DRAIN: begin
        if (bits_q >= 5'd8) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = 8'(buf_q >> bits_m8);
            out_end_d   = (phase_q == PH_ENDC) && (bits_m8 == 5'd0);
            buf_d       = buf_q & ((BUF_BITS'(1) << bits_m8) - BUF_BITS'(1));
            bits_d      = bits_m8;
          end
        end else begin
          case (phase_q)
            PH_MISS: begin
              if (clr_q) begin
                code_d  = W'(CLEAR_CODE);
                w_d     = width_q;
                phase_d = PH_CLEAR;
              end
            end
            PH_CLEAR: begin
              width_d = 5'(START_WIDTH);
              free_d  = FW'(FIRST_FREE);
              clr_d   = 1'b0;
            end
            PH_FINAL: begin
              code_d  = W'(END_CODE);
              w_d     = width_q;
              phase_d = PH_ENDC;
            end
            PH_ENDC: begin
              if (bits_q == 5'd0) begin
                have_d   = 1'b0;
                prefix_d = '0;
                free_d   = FW'(FIRST_FREE);
                width_d  = 5'(START_WIDTH);
                buf_d    = '0;
                clr_d    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LASTCHK: begin
        if (last_q) begin
          code_d  = prefix_q;
          w_d     = width_q;
          phase_d = PH_FINAL;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'(buf_q << (5'd8 - bits_q));
          out_end_d   = 1'b1;
          have_d      = 1'b0;
          prefix_d    = '0;
          free_d      = FW'(FIRST_FREE);
          width_d     = 5'(START_WIDTH);
          buf_d       = '0;
          bits_d      = 5'd0;
          clr_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MISS;
      prefix_q    <= '0;
      have_q      <= 1'b0;
      free_q      <= FW'(FIRST_FREE);
      width_q     <= 5'(START_WIDTH);
      buf_q       <= '0;
      bits_q      <= 5'd0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      prefix_q    <= prefix_d;
      have_q      <= have_d;
      free_q      <= free_d;
      width_q     <= width_d;
      buf_q       <= buf_d;
      bits_q      <= bits_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    w_q        <= w_d;
    last_q     <= last_d;
    byte_q     <= byte_d;
    idx_q      <= idx_d;
    cand_q     <= cand_d;
    inr_q      <= inr_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;

  // The next free code never passes the size of the widest dictionary.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= (FW'(1) << W))
    else $error("free code beyond dictionary size");

  // Between items at most seven bits are left waiting in the packer.
  a_idle_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (bits_q < 5'd8))
    else $error("packer holds a whole byte while idle");

  // Only the engine pops the queue, and only from idle.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE) && q_valid_i)
    else $error("queue popped outside idle");

  // A dictionary write always belongs to a miss.
  a_write_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    child_we |=> (state_q == ST_PUT) && (phase_q == PH_MISS))
    else $error("dictionary written without a miss");

endmodule

### sv/lzw_variable_width_encoder_core.sv
// Channel   Direction  Contents
// s_axis    in         tdata: data_byte[7:0]; tlast: last_byte
// m_axis    out        tdata: out_byte[7:0]; tlast: stream_end
// apb       in/out     register 0 at address 0: max_code_bits[4:0]
//
// The first byte of a stream takes the queue pop and the last-byte check.
// A later byte found in the dictionary takes the pop with the child-table read,
// the key-table read that confirms the entry, the decision and the last-byte check.
// A miss, a clear code and each final code add a pack step, a drain step per output word
// and a closing drain step; a partial last word adds padding. Reset needs no clearing
// pass; a dictionary is emptied by resetting the free code. A stalled output port holds
// the engine in its drain step; the two-word input queue keeps accepting until full.
module lzw_variable_width_encoder_core
  import lzw_pkg::*;
#(
  parameter int unsigned WIDEST_CODE = WIDEST_CODE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] max_bits_q;
  logic       q_valid, q_pop;
  item_t      in_item, q_item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_CODE_BITS) ? {27'd0, max_bits_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q <= 5'(DEF_MAX_BITS);
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_CODE_BITS)) begin
      max_bits_q <= pwdata[4:0];
    end
  end

  assign in_item.last = s_axis_tlast;
  assign in_item.data = s_axis_tdata;

  lzw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  lzw_back #(.WIDEST_CODE(WIDEST_CODE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_bits_i  (max_bits_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_end_o   (m_axis_tlast)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lzw_pkg::*;

  typedef struct {
    logic [7:0] code_byte;
    logic       end_flag;
  } packed_word_t;

  // Mirrors the encoder: dictionary, prefix, width growth and MSB-first bit packing.
  class lzw_scoreboard;
    packed_word_t    pending_words[$];
    int unsigned     failures;
    int unsigned     width_limit_reg;
    logic [15:0]     dict[int unsigned];
    int unsigned     prefix;
    bit              have_prefix;
    int unsigned     free_code;
    int unsigned     code_width;
    int unsigned     grow_limit;
    int unsigned     bit_buf;
    int unsigned     bit_count;

    function void restart_stream();
      dict.delete();
      prefix      = 0;
      have_prefix = 0;
      free_code   = FIRST_FREE;
      code_width  = START_WIDTH;
      grow_limit  = 512;
      bit_buf     = 0;
      bit_count   = 0;
    endfunction

    function void set_limit(int unsigned v);
      width_limit_reg = v & 32'h1f;
    endfunction

    function int unsigned eff_limit();
      int unsigned m;
      m = width_limit_reg;
      if (m > WIDEST_CODE_DEF) m = WIDEST_CODE_DEF;
      if (m < START_WIDTH) m = (DEF_MAX_BITS < WIDEST_CODE_DEF) ? DEF_MAX_BITS : WIDEST_CODE_DEF;
      return m;
    endfunction

    function void push_word(int unsigned b);
      packed_word_t w;
      w.code_byte = b[7:0];
      w.end_flag  = 1'b0;
      pending_words.push_back(w);
    endfunction

    function void pack_code(int unsigned code, int unsigned w);
      bit_buf   = ((bit_buf << w) | (code & ((1 << w) - 1))) & 32'hff_ffff;
      bit_count += w;
      while (bit_count >= 8) begin
        bit_count -= 8;
        push_word(bit_buf >> bit_count);
        bit_buf &= (1 << bit_count) - 1;
      end
    endfunction

    function void note_byte(logic [7:0] d, logic last);
      int unsigned key;
      if (!have_prefix) begin
        prefix      = d;
        have_prefix = 1;
      end else begin
        key = ((prefix & ((1 << WIDEST_CODE_DEF) - 1)) << 8) | d;
        if (dict.exists(key) && dict[key] != 0) begin
          prefix = dict[key];
        end else begin
          pack_code(prefix, code_width);
          dict[key] = free_code[15:0];
          free_code++;
          prefix = d;
          if (free_code == grow_limit) begin
            code_width++;
            if (code_width > eff_limit()) begin
              pack_code(CLEAR_CODE, code_width);
              dict.delete();
              code_width = START_WIDTH;
              grow_limit = 512;
              free_code  = FIRST_FREE;
            end else begin
              grow_limit <<= 1;
            end
          end
        end
      end
      if (last) begin
        pack_code(prefix, code_width);
        pack_code(END_CODE, code_width);
        if (bit_count != 0) push_word(bit_buf << (8 - bit_count));
        pending_words[$].end_flag = 1'b1;
        restart_stream();
      end
    endfunction

    function void check_word(logic [7:0] d, logic end_flag);
      packed_word_t e;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual data %h last %b",
                 $time, d, end_flag);
        failures++;
        return;
      end
      e = pending_words.pop_front();
      if (e.code_byte !== d || e.end_flag !== end_flag) begin
        $display("%0t: word mismatch: expected data %h last %b, actual data %h last %b",
                 $time, e.code_byte, e.end_flag, d, end_flag);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte[7:0]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte[7:0]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lzw_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  lzw_variable_width_encoder_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(logic [7:0] d, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(d, last);
  endtask

  task automatic send_stream(int unsigned len, bit narrow);
    logic [7:0] d;
    for (int unsigned i = 0; i < len; i++) begin
      d = narrow ? 8'($urandom_range(3) + 8'h41) : 8'($urandom_range(255));
      send_byte(d, i == len - 1);
    end
  endtask

  // Lets the encoder finish everything in flight before the register changes.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_max_bits(int unsigned v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_MAX_CODE_BITS);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_limit(v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned limits[7] = '{9, 16, 3, 10, 0, 31, 12};
    sb = new();
    sb.set_limit(DEF_MAX_BITS);
    sb.restart_stream();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte streams at both byte extremes, then a two-byte stream.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    // A run of one byte exercises dictionary hits.
    for (int i = 0; i < 8; i++) send_byte(8'h61, i == 7);

    for (int p = 0; p < 7; p++) begin
      settle();
      write_max_bits(limits[p]);
      case (p % 3)
        0: begin send_idle_pct = 35; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // At the narrowest limit one long stream of random bytes should force a clear.
      if (p == 0) send_stream(262, 1'b0);
      for (int s = 0; s < 2; s++) send_stream($urandom_range(4, 1), 1'($urandom_range(1)));
    end

    settle();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/lzw_pkg.sv
sv/lzw_ram.sv
sv/lzw_front.sv
sv/lzw_back.sv
sv/lzw_variable_width_encoder_core.sv
test/tb_top.sv
